[design/ddt_pkg.sv]
`timescale 1ns / 1ps

package ddt_pkg;

    localparam int FRAC_BITS_DEFAULT = 8;
    localparam int PIX_W             = 8;
    localparam int IN_DATA_W         = 48;
    localparam int OUT_DATA_W        = 8;
    localparam int TAPS              = 3;

    typedef logic [PIX_W-1:0] pixel_t;

    // last member sits in the lowest bits, so this matches the tdata layout
    typedef struct packed {
        pixel_t frac_y;
        pixel_t frac_x;
        pixel_t bottom_right;
        pixel_t bottom_left;
        pixel_t top_right;
        pixel_t top_left;
    } pix_item_t;

endpackage

[design/ddt_tri_select.sv]
`timescale 1ns / 1ps

module ddt_tri_select #(
    parameter int FRAC_BITS = ddt_pkg::FRAC_BITS_DEFAULT
) (
    input  ddt_pkg::pix_item_t                             item,
    output logic [ddt_pkg::TAPS-1:0][FRAC_BITS+1:0]        weight,
    output ddt_pkg::pixel_t [ddt_pkg::TAPS-1:0]            pixel
);

    localparam int W = FRAC_BITS + 2;
    localparam logic [31:0]  FRAC_LIM = (32'd1 << FRAC_BITS) - 32'd1;
    localparam logic [W-1:0] ONE      = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] TOTAL    = W'(1) << (FRAC_BITS + 1);

    logic [W-1:0]         fx;
    logic [W-1:0]         fy;
    ddt_pkg::pixel_t      asc_diff;
    ddt_pkg::pixel_t      desc_diff;

    // fractions of one or more saturate just below one
    always_comb
    begin
        fx = (32'(item.frac_x) > FRAC_LIM) ? FRAC_LIM[W-1:0] : W'(item.frac_x);
        fy = (32'(item.frac_y) > FRAC_LIM) ? FRAC_LIM[W-1:0] : W'(item.frac_y);
    end

    always_comb
    begin
        asc_diff  = (item.bottom_left > item.top_right)
                  ? item.bottom_left - item.top_right
                  : item.top_right - item.bottom_left;
        desc_diff = (item.top_left > item.bottom_right)
                  ? item.top_left - item.bottom_right
                  : item.bottom_right - item.top_left;
    end

    // diagonal tie goes to the second pair of triangles
    always_comb
    begin
        if (asc_diff > desc_diff)
        begin
            if (fy > fx)
            begin
                weight[0] = ONE - fy;
                weight[1] = fx;
                pixel[0]  = item.top_left;
                pixel[1]  = item.bottom_right;
                pixel[2]  = item.bottom_left;
            end
            else
            begin
                weight[0] = ONE - fx;
                weight[1] = fy;
                pixel[0]  = item.top_left;
                pixel[1]  = item.bottom_right;
                pixel[2]  = item.top_right;
            end
        end
        else
        begin
            if ((fx + fy) < ONE)
            begin
                weight[0] = fx;
                weight[1] = fy;
                pixel[0]  = item.top_right;
                pixel[1]  = item.bottom_left;
                pixel[2]  = item.top_left;
            end
            else
            begin
                weight[0] = ONE - fy;
                weight[1] = ONE - fx;
                pixel[0]  = item.top_right;
                pixel[1]  = item.bottom_left;
                pixel[2]  = item.bottom_right;
            end
        end
        weight[2] = TOTAL - weight[0] - weight[1];
    end

endmodule

[design/ddt_pixel_interpolator_top.sv]
`timescale 1ns / 1ps

// data-dependent triangulation pixel interpolator
//
// input stream: one transfer per output pixel carrying the four neighbouring
// source pixels and the x and y sub-pixel fractions (units of 2^-FRAC_BITS)
// output stream: one transfer per input transfer with the interpolated pixel,
// in the same order
//
// two register stages: input register, then the weighted sum in the output
// register; m_tvalid rises as a pixel enters it. with m_tready high, throughput
// is one pixel per cycle, set by the single multiply-add stage.
//
// reset empties both stages; no output is presented until new input arrives.
// when m_tready is low the output register holds, the input register fills
// behind it, and s_tready drops only once both stages hold data.
module ddt_pixel_interpolator_top #(
    parameter int FRAC_BITS = ddt_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // top_left, top_right, bottom_left, bottom_right, frac_x, frac_y
    input  logic [ddt_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // interpolated
    output logic [ddt_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int W  = FRAC_BITS + 2;
    localparam int SW = FRAC_BITS + 10;
    localparam logic [W-1:0] TOTAL = W'(1) << (FRAC_BITS + 1);

    ddt_pkg::pix_item_t                          item_reg;
    logic                                        item_vld_reg;
    logic [ddt_pkg::TAPS-1:0][W-1:0]             weight;
    ddt_pkg::pixel_t [ddt_pkg::TAPS-1:0]         pixel;
    logic [ddt_pkg::OUT_DATA_W-1:0]              out_reg;
    logic                                        out_vld_reg;
    logic                                        out_adv;
    logic [SW-1:0]                               sum;

    assign out_adv  = !out_vld_reg || m_tready;
    assign s_tready = !item_vld_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
                item_vld_reg <= s_tvalid;
            if (out_adv)
                out_vld_reg <= item_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= ddt_pkg::pix_item_t'(s_tdata);
        if (out_adv && item_vld_reg)
            out_reg <= sum[FRAC_BITS+8:FRAC_BITS+1];
    end

    ddt_tri_select #(
        .FRAC_BITS (FRAC_BITS)
    ) u_tri_select (
        .item   (item_reg),
        .weight (weight),
        .pixel  (pixel)
    );

    // weights sum to two in units of 2^-FRAC_BITS, so the sum cannot wrap
    assign sum = (SW'(weight[0]) * SW'(pixel[0]))
               + (SW'(weight[1]) * SW'(pixel[1]))
               + (SW'(weight[2]) * SW'(pixel[2]));

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_tready)
        else $error("input stalled while output stage empty");

    a_item_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && s_tready) |=> out_vld_reg)
        else $error("pixel lost between input and output stage");

    a_weight_total: assert property (@(posedge clk) disable iff (!rst_n)
        item_vld_reg |-> ((W+1)'(weight[0]) + (W+1)'(weight[1]) + (W+1)'(weight[2]))
                         == (W+1)'(TOTAL))
        else $error("triangle weights do not sum to two");
`endif

endmodule
